// ===== rtl/nfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// nfsa_pkg
// Shared types, constants and helpers of the next-fit slot allocator.
// ----------------------------------------------------------------------------
package nfsa_pkg;

  // Pool size and derived geometry of the in-use bitmap
  localparam int unsigned SLOTS  = 1024;
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned PTR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned WORD_W = (SLOTS >= 32) ? 32 : (2 ** PTR_W);
  localparam int unsigned BIT_W  = $clog2(WORD_W);
  localparam int unsigned WORDS  = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int unsigned WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CNT_W  = $clog2(WORDS + 1);
  localparam int unsigned TAIL   = SLOTS - (WORDS - 1) * WORD_W;

  // Request codes
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Response status codes
  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RELEASED  = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [SLOT_W-1:0] slot_id;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] granted_slot;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic lookup;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;
    logic out_free;
  } stat_t;

  // Bits of the last word that lie beyond the pool read as used
  function automatic logic [WORD_W-1:0] pad_mask(logic [WIDX_W-1:0] w);
    logic [WORD_W-1:0] m;
    m = '0;
    if (32'(w) == WORDS - 1) begin
      for (int i = 0; i < WORD_W; i++) begin
        if (i >= TAIL) m[i] = 1'b1;
      end
    end
    return m;
  endfunction

  // Index of the lowest set bit
  function automatic logic [BIT_W-1:0] first_one(logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [PTR_W-1:0] slot_index(logic [SLOT_W-1:0] s);
    logic [31:0] t;
    t = 32'(s);
    return t[PTR_W-1:0];
  endfunction

  function automatic logic slot_in_pool(logic [SLOT_W-1:0] s);
    return 32'(s) < SLOTS;
  endfunction

  function automatic logic [WIDX_W-1:0] word_of(logic [PTR_W-1:0] idx);
    logic [31:0] t;
    t = 32'(idx) >> BIT_W;
    return t[WIDX_W-1:0];
  endfunction

endpackage

// ===== rtl/nfsa_ram.sv =====
// ----------------------------------------------------------------------------
// nfsa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nfsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/nfsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// nfsa_ctrl
// Sequencer: accept a request, run the bitmap lookup, hand off the response.
// ----------------------------------------------------------------------------
module nfsa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  nfsa_pkg::stat_t stat_i,
  output nfsa_pkg::cmd_t  cmd_o
);
  import nfsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;

  always_comb begin
    state_d    = state_q;
    stall_d    = stall_q;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_LOOKUP;
          stall_d     = 1'b1;
        end
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        if (stat_i.done) state_d = S_EMIT;
      end
      S_EMIT: begin
        // wait for the output register to drain
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
          stall_d    = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
        stall_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  assign in_stall_o = stall_q;

endmodule

// ===== rtl/nfsa_dp.sv =====
// ----------------------------------------------------------------------------
// nfsa_dp
// Bitmap datapath: word-wide next-fit scan, release update, response register.
// ----------------------------------------------------------------------------
module nfsa_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nfsa_pkg::req_t  in_req_i,
  input  nfsa_pkg::cmd_t  cmd_i,
  output nfsa_pkg::stat_t stat_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output nfsa_pkg::rsp_t  out_rsp_o
);
  import nfsa_pkg::*;

  req_t              req_q;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [WIDX_W-1:0] widx_q, next_widx, start_addr;
  logic [CNT_W-1:0]  cnt_q;
  logic              first_q;
  logic [WORDS-1:0]  valid_q;
  rsp_t              res_q, res_d;
  rsp_t              out_q;
  logic              out_valid_q;

  logic              ram_we, ram_re;
  logic [WIDX_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic [WORD_W-1:0] cur_raw, cur_used, free_bits, allow;
  logic [BIT_W-1:0]  fbit, rel_bit, ptr_bit;
  logic [PTR_W-1:0]  alloc_idx, rel_idx;
  logic [31:0]       gidx, alloc_ext;
  logic              found, exhausted, is_rel, in_pool, done;

  nfsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS),
    .AW    (WIDX_W)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ptr_bit    = ptr_q[BIT_W-1:0];
    start_addr = (in_req_i.req_type == REQ_RELEASE) ? word_of(slot_index(in_req_i.slot_id))
                                                    : word_of(ptr_q);
    next_widx  = (32'(widx_q) == WORDS - 1) ? '0 : widx_q + 1'b1;

    // a word never written reads as all free
    cur_raw   = valid_q[widx_q] ? ram_rdata : '0;
    cur_used  = cur_raw | pad_mask(widx_q);
    allow     = first_q ? ({WORD_W{1'b1}} << ptr_bit) : {WORD_W{1'b1}};
    free_bits = ~cur_used & allow;
    found     = |free_bits;
    fbit      = first_one(free_bits);
    gidx      = (32'(widx_q) << BIT_W) | 32'(fbit);
    alloc_idx = gidx[PTR_W-1:0];
    alloc_ext = 32'(alloc_idx);
    exhausted = (32'(cnt_q) == WORDS);

    is_rel    = (req_q.req_type == REQ_RELEASE);
    rel_idx   = slot_index(req_q.slot_id);
    rel_bit   = rel_idx[BIT_W-1:0];
    in_pool   = slot_in_pool(req_q.slot_id);

    done      = cmd_i.lookup && (is_rel || found || exhausted);
    ram_we    = cmd_i.lookup && (is_rel ? in_pool : found);
    ram_wdata = is_rel ? (cur_raw & ~(WORD_W'(1) << rel_bit))
                       : (cur_raw | (WORD_W'(1) << fbit));
    // read ahead the next word while the current one is checked
    ram_re    = cmd_i.start || cmd_i.lookup;
    ram_raddr = cmd_i.start ? start_addr : next_widx;

    ptr_d = (alloc_ext == SLOTS - 1) ? '0 : alloc_idx + 1'b1;

    if (is_rel) begin
      res_d.status       = ST_RELEASED;
      res_d.granted_slot = req_q.slot_id;
    end else if (found) begin
      res_d.status       = ST_ALLOCATED;
      res_d.granted_slot = alloc_ext[SLOT_W-1:0];
    end else begin
      res_d.status       = ST_FULL;
      res_d.granted_slot = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      widx_q      <= '0;
      cnt_q       <= '0;
      first_q     <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        widx_q  <= start_addr;
        cnt_q   <= '0;
        first_q <= 1'b1;
      end else if (cmd_i.lookup && !done) begin
        widx_q  <= next_widx;
        cnt_q   <= cnt_q + CNT_W'(1);
        first_q <= 1'b0;
      end
      if (ram_we) valid_q[widx_q] <= 1'b1;
      if (cmd_i.lookup && !is_rel && found) ptr_q <= ptr_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) req_q <= in_req_i;
    if (done)        res_q <= res_d;
    if (cmd_i.emit)  out_q <= res_q;
  end

  assign stat_o.done     = done;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_rsp_o       = out_q;

endmodule

// ===== rtl/next_fit_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// next_fit_slot_allocator
// Next-fit slot allocator over a fixed pool with an in-use bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o / in_req_i): allocate a free slot
//   or release a given one. Response channel (out_valid_o / out_stall_i /
//   out_rsp_o): exactly one response per request, in request order.
//   The bitmap is held as SLOTS/32 words of 32 bits in a RAM with registered
//   read; an allocation checks one word per cycle from the search pointer,
//   wrapping, reading the next word ahead while the current one is checked.
//   A release or an allocation is answered through the result register and then
//   the output register; an allocation scans word by word from the pointer's
//   word, wrapping back to it, and answers full once every word is checked.
//   One request is in flight at a time; the next is accepted once the
//   response is loaded into the output register, so the request side is
//   free again while a response waits there.
//   Reset marks every slot free at once (one valid bit per bitmap word) and
//   clears the search pointer; no clearing pass is needed.
//   A stalled response is held unchanged until taken; the request side accepts
//   one further request meanwhile and stalls until its response can be loaded.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  nfsa_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output nfsa_pkg::rsp_t out_rsp_o
);
  import nfsa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  nfsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  nfsa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ===== rtl/nfsa_checker.sv =====
// ----------------------------------------------------------------------------
// nfsa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module nfsa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input nfsa_pkg::req_t in_req_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input nfsa_pkg::rsp_t out_rsp_o
);
  import nfsa_pkg::*;

  // one request at a time: stall right after an accept
  a_single_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response dropped or changed");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == ST_FULL |-> out_rsp_o.granted_slot == '0)
    else $error("full response carries a slot number");

  // release with an empty output register answers in fixed time, echoing the slot
  a_release_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_req_i.req_type == REQ_RELEASE && !out_valid_o
    |=> ##2 out_valid_o && out_rsp_o.status == ST_RELEASED
            && out_rsp_o.granted_slot == $past(in_req_i.slot_id, 3))
    else $error("release response wrong or late");

endmodule

bind next_fit_slot_allocator nfsa_checker u_nfsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
